// ----- rtl/core/qrst_pkg.sv -----
// ----------------------------------------------------------------------------
// qrst_pkg
// shared types and constants of the quadtree region split test
// ----------------------------------------------------------------------------
package qrst_pkg;

	localparam int PixW  = 8;
	localparam int CrdW  = 16;
	localparam int DimW  = 13;
	localparam int NumCh = 3;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_DIV,
		BK_SCAN,
		BK_QDIV,
		BK_OUT
	} bk_state_t;

endpackage

// ----- rtl/core/qrst_ram.sv -----
// ----------------------------------------------------------------------------
// qrst_ram
// single port ram, one write or one read a cycle, registered read data
// ----------------------------------------------------------------------------
module qrst_ram #(
	parameter int Width = 24,
	parameter int Depth = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(Depth)-1:0] addr,
	input  logic [Width-1:0]         wdata,
	output logic [Width-1:0]         rdata
);
	logic [Width-1:0] mem_q [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end
endmodule

// ----- rtl/core/qrst_divu.sv -----
// ----------------------------------------------------------------------------
// qrst_divu
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module qrst_divu #(
	parameter int NumW = 40,
	parameter int DenW = 28
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [NumW-1:0] num,
	input  logic [DenW-1:0] den,
	output logic            busy,
	output logic [NumW-1:0] quot
);
	localparam int CntW = $clog2(NumW + 1);
	logic [NumW-1:0] q_q;
	logic [DenW:0]   rem_q;
	logic [DenW-1:0] den_q;
	logic [CntW-1:0] cnt_q;
	logic [DenW:0]   trial;
	logic [DenW:0]   shifted;

	assign shifted = {rem_q[DenW-1:0], q_q[NumW-1]};
	assign trial   = shifted - {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= CntW'(NumW);
		end else if (cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			q_q   <= num;
			rem_q <= '0;
			den_q <= den;
		end else if (cnt_q != '0) begin
			if (!trial[DenW]) begin
				rem_q <= trial;
				q_q   <= {q_q[NumW-2:0], 1'b1};
			end else begin
				rem_q <= shifted;
				q_q   <= {q_q[NumW-2:0], 1'b0};
			end
		end
	end

	assign busy = (cnt_q != '0);
	assign quot = q_q;
endmodule

// ----- rtl/core/qrst_front.sv -----
// ----------------------------------------------------------------------------
// qrst_front
// takes pixels, writes the store, sums channels, latches the region
// ----------------------------------------------------------------------------
module qrst_front
	import qrst_pkg::*;
#(
	parameter int MaxPix = 4096,
	parameter int CntW   = 13,
	parameter int SumW   = 20
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                pix_valid,
	output logic                pix_ready,
	input  logic [3*PixW-1:0]   pix_rgb,
	input  logic [CrdW-1:0]     pix_x,
	input  logic [CrdW-1:0]     pix_y,
	input  logic [DimW-1:0]     pix_w,
	input  logic [DimW-1:0]     pix_h,
	input  logic                pix_last,
	input  logic                back_busy,
	output logic                st_we,
	output logic [CntW-1:0]     st_addr,
	output logic [3*PixW-1:0]   st_wdata,
	output logic                job_valid,
	output logic [CrdW-1:0]     job_x,
	output logic [CrdW-1:0]     job_y,
	output logic [2*DimW-1:0]   job_area,
	output logic [CntW:0]       job_count,
	output logic [3*SumW-1:0]   job_sums
);
	logic [CntW:0]     cnt_q;
	logic [CrdW-1:0]   x_q, y_q;
	logic [DimW-1:0]   w_q, h_q;
	logic [SumW-1:0]   rs_q, gs_q, bs_q;
	logic              acc;
	logic              first;
	logic              room;
	logic [CrdW-1:0]   cx, cy;
	logic [DimW-1:0]   cw, ch;
	logic [SumW-1:0]   nr, ng, nb;
	logic [CntW:0]     ncnt;

	// front holds while back still owns the store
	assign pix_ready = !back_busy;
	assign acc       = pix_valid && pix_ready;
	assign first     = (cnt_q == '0);
	assign room      = (cnt_q < (CntW+1)'(MaxPix));
	assign cx = first ? pix_x : x_q;
	assign cy = first ? pix_y : y_q;
	assign cw = first ? pix_w : w_q;
	assign ch = first ? pix_h : h_q;
	assign nr = room ? rs_q + SumW'(pix_rgb[23:16]) : rs_q;
	assign ng = room ? gs_q + SumW'(pix_rgb[15:8]) : gs_q;
	assign nb = room ? bs_q + SumW'(pix_rgb[7:0]) : bs_q;
	assign ncnt = room ? cnt_q + 1'b1 : (CntW+1)'(MaxPix + 1);

	assign st_we    = acc && room;
	assign st_addr  = cnt_q[CntW-1:0];
	assign st_wdata = pix_rgb;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			x_q <= '0; y_q <= '0; w_q <= '0; h_q <= '0;
			rs_q <= '0; gs_q <= '0; bs_q <= '0;
			job_valid <= 1'b0;
		end else begin
			job_valid <= acc && pix_last;
			if (acc) begin
				if (pix_last) begin
					cnt_q <= '0;
					x_q <= '0; y_q <= '0; w_q <= '0; h_q <= '0;
					rs_q <= '0; gs_q <= '0; bs_q <= '0;
				end else begin
					cnt_q <= ncnt;
					x_q <= cx; y_q <= cy; w_q <= cw; h_q <= ch;
					rs_q <= nr; gs_q <= ng; bs_q <= nb;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc && pix_last) begin
			job_x     <= cx;
			job_y     <= cy;
			job_area  <= cw * ch;
			job_count <= ncnt;
			job_sums  <= {nr, ng, nb};
		end
	end
endmodule

// ----- rtl/core/qrst_back.sv -----
// ----------------------------------------------------------------------------
// qrst_back
// averages, deviation scan over the store, q8 divide, result register
// ----------------------------------------------------------------------------
module qrst_back
	import qrst_pkg::*;
#(
	parameter int MaxPix = 4096,
	parameter int CntW   = 13,
	parameter int SumW   = 20
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [PixW-1:0]   threshold,
	input  logic              job_valid,
	input  logic [CrdW-1:0]   job_x,
	input  logic [CrdW-1:0]   job_y,
	input  logic [2*DimW-1:0] job_area,
	input  logic [CntW:0]     job_count,
	input  logic [3*SumW-1:0] job_sums,
	output logic              busy,
	output logic              rd_en,
	output logic [CntW-1:0]   rd_addr,
	input  logic [3*PixW-1:0] rd_data,
	output logic              res_valid,
	input  logic              res_ready,
	output logic [87:0]       res_data
);
	localparam int AreaW = 2 * DimW;
	localparam int DenW  = AreaW + 2;
	localparam int SW    = CntW + 10;
	localparam int NumW  = SW + 8;

	bk_state_t st_q, st_d;
	logic [CrdW-1:0]  x_q, y_q;
	logic [AreaW-1:0] area_q;
	logic [CntW:0]    cnt_q;
	logic             err_q;
	logic [SumW-1:0]  sum_q [NumCh];
	logic [PixW-1:0]  avg_q [NumCh];
	logic [1:0]       ch_q;
	logic [CntW:0]    idx_q;
	logic             rv_s1;
	logic [SW-1:0]    s_q;
	logic [PixW-1:0]  pr, pg, pb;
	logic [PixW+1:0]  dsum;
	logic [DenW-1:0]  den;
	logic             dv_start;
	logic [NumW-1:0]  dv_num;
	logic [DenW-1:0]  dv_den;
	logic             dv_busy;
	logic [NumW-1:0]  dv_quot;
	logic             dv_go_q;
	logic [DenW+PixW-1:0] thr_prod;

	function automatic logic [PixW-1:0] adiff(input logic [PixW-1:0] a, input logic [PixW-1:0] b);
		adiff = (a > b) ? a - b : b - a;
	endfunction

	assign den = DenW'(area_q) + DenW'({area_q, 1'b0});
	assign {pr, pg, pb} = rd_data;
	assign dsum = (PixW+2)'(adiff(avg_q[0], pr)) + (PixW+2)'(adiff(avg_q[1], pg))
		+ (PixW+2)'(adiff(avg_q[2], pb));
	assign thr_prod = threshold * den;

	qrst_divu #(.NumW(NumW), .DenW(DenW)) u_div (
		.clk(clk), .arst_n(arst_n), .start(dv_start), .num(dv_num), .den(dv_den),
		.busy(dv_busy), .quot(dv_quot)
	);

	assign dv_start = (st_q == BK_DIV || st_q == BK_QDIV) && dv_go_q;
	assign dv_num = (st_q == BK_DIV) ? NumW'(sum_q[ch_q]) : {s_q, 8'd0};
	assign dv_den = (st_q == BK_DIV) ? DenW'(area_q) : den;

	always_comb begin
		st_d = st_q;
		case (st_q)
			BK_IDLE: if (job_valid) st_d = BK_DIV;
			BK_DIV:  if (!dv_go_q && !dv_busy && ch_q == 2'd2) st_d = BK_SCAN;
			BK_SCAN: if (!rd_en && !rv_s1) st_d = BK_QDIV;
			BK_QDIV: if (!dv_go_q && !dv_busy) st_d = BK_OUT;
			// wait until the output register is free
			BK_OUT:  if (!res_valid || res_ready) st_d = BK_IDLE;
			default: st_d = BK_IDLE;
		endcase
	end

	always_comb begin
		busy    = (st_q != BK_IDLE) || job_valid;
		rd_en   = (st_q == BK_SCAN) && (idx_q < cnt_q);
		rd_addr = idx_q[CntW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= BK_IDLE;
			res_valid <= 1'b0;
			dv_go_q <= 1'b0;
			rv_s1 <= 1'b0;
		end else begin
			st_q <= st_d;
			rv_s1 <= rd_en;
			dv_go_q <= (st_q == BK_IDLE && job_valid)
				|| (st_q == BK_DIV && !dv_go_q && !dv_busy && ch_q != 2'd2)
				|| (st_q == BK_SCAN && st_d == BK_QDIV);
			if (st_q == BK_OUT && st_d == BK_IDLE) res_valid <= 1'b1;
			else if (res_ready) res_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == BK_IDLE && job_valid) begin
			x_q <= job_x; y_q <= job_y; area_q <= job_area; cnt_q <= job_count;
			err_q <= (job_count > (CntW+1)'(MaxPix)) || (AreaW'(job_count) != job_area)
				|| (job_area > AreaW'(MaxPix));
			sum_q[0] <= job_sums[3*SumW-1:2*SumW];
			sum_q[1] <= job_sums[2*SumW-1:SumW];
			sum_q[2] <= job_sums[SumW-1:0];
			ch_q <= '0; idx_q <= '0; s_q <= '0;
		end
		if (st_q == BK_DIV && !dv_go_q && !dv_busy) begin
			avg_q[ch_q] <= dv_quot[PixW-1:0];
			if (ch_q != 2'd2) ch_q <= ch_q + 1'b1;
		end
		if (rd_en) idx_q <= idx_q + 1'b1;
		if (rv_s1) s_q <= s_q + SW'(dsum);
		if (st_q == BK_OUT && st_d == BK_IDLE) begin
			res_data <= {14'd0, err_q, !err_q && (DenW+PixW)'(s_q) > thr_prod,
				err_q ? 16'd0 : dv_quot[15:0],
				err_q ? 8'd0 : avg_q[2], err_q ? 8'd0 : avg_q[1],
				err_q ? 8'd0 : avg_q[0], y_q, x_q};
		end
	end
endmodule

// ----- rtl/core/quadtree_region_split_test.sv -----
// ----------------------------------------------------------------------------
// quadtree_region_split_test
// region mean absolute deviation and split decision over stored pixels
// ----------------------------------------------------------------------------
// channel  dir  words
// s_axis   in   one pixel per word, tlast ends the region
// m_axis   out  one result word per region
// cfg      in   detail threshold
//
// pixels load at one per cycle into the store while the back end is idle;
// on tlast the back end runs three divides, one scan over the stored pixels,
// a q8 divide and a load of the output register, where the result waits;
// the next region loads meanwhile; its result waits until that word is taken.
// s_axis_tready is low while the back end owns the store.
// reset is asynchronous; the store holds no reset state.
// ----------------------------------------------------------------------------
module quadtree_region_split_test
	import qrst_pkg::*;
#(
	parameter int MAX_REGION_PIXELS = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// red, green, blue, region_x, region_y, region_width, region_height, pad
	input  logic [87:0] s_axis_tdata,
	input  logic        s_axis_tlast,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// out_x, out_y, avg_red, avg_green, avg_blue, detail_q8, split, count_error
	output logic [87:0] m_axis_tdata,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data
);
	localparam int CntW = $clog2(MAX_REGION_PIXELS);
	localparam int SumW = CntW + 8;

	logic [7:0]        thr_q;
	logic              st_we, rd_en, back_busy, job_valid;
	logic [CntW-1:0]   st_addr, rd_addr;
	logic [23:0]       st_wdata, rd_data;
	logic [CrdW-1:0]   job_x, job_y;
	logic [2*DimW-1:0] job_area;
	logic [CntW:0]     job_count;
	logic [3*SumW-1:0] job_sums;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) thr_q <= '0;
		else if (cfg_valid) thr_q <= cfg_data;
	end

	qrst_front #(.MaxPix(MAX_REGION_PIXELS), .CntW(CntW), .SumW(SumW)) u_front (
		.clk(clk), .arst_n(arst_n), .pix_valid(s_axis_tvalid), .pix_ready(s_axis_tready),
		.pix_rgb({s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]}),
		.pix_x(s_axis_tdata[39:24]), .pix_y(s_axis_tdata[55:40]),
		.pix_w(s_axis_tdata[68:56]), .pix_h(s_axis_tdata[81:69]), .pix_last(s_axis_tlast),
		.back_busy(back_busy), .st_we(st_we), .st_addr(st_addr), .st_wdata(st_wdata),
		.job_valid(job_valid), .job_x(job_x), .job_y(job_y), .job_area(job_area),
		.job_count(job_count), .job_sums(job_sums)
	);

	// store port shared: front writes while loading, back reads while scanning
	qrst_ram #(.Width(24), .Depth(MAX_REGION_PIXELS)) u_store (
		.clk(clk), .we(st_we), .addr(st_we ? st_addr : rd_addr),
		.wdata(st_wdata), .rdata(rd_data)
	);

	qrst_back #(.MaxPix(MAX_REGION_PIXELS), .CntW(CntW), .SumW(SumW)) u_back (
		.clk(clk), .arst_n(arst_n), .threshold(thr_q), .job_valid(job_valid),
		.job_x(job_x), .job_y(job_y), .job_area(job_area), .job_count(job_count),
		.job_sums(job_sums), .busy(back_busy), .rd_en(rd_en), .rd_addr(rd_addr),
		.rd_data(rd_data), .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
		.res_data(m_axis_tdata)
	);

	// no pixel taken while a region is being evaluated
	a_no_take_busy: assert property (@(posedge clk) disable iff (!arst_n)
		back_busy |-> !s_axis_tready) else $error("pixel taken while busy");
	// store never written during the scan
	a_no_wr_scan: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en |-> !st_we) else $error("store port clash");
	// a waiting result word holds until taken
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result word changed while waiting");
endmodule

// ----- tb/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the quadtree region split test
// ----------------------------------------------------------------------------
// streams rgb regions into the block and predicts each region's averages,
// mean absolute deviation and split flag in a small scoreboard. directed
// regions first: extremes, single pixel, count errors and a larger region.
// then random regions, mostly well formed, under several idle and stall
// patterns and threshold settings.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import qrst_pkg::*;

	localparam int StoreDepth = 4096;

	// one result word as the block reports it
	typedef struct {
		logic [CrdW-1:0] x;
		logic [CrdW-1:0] y;
		logic [PixW-1:0] avg_r;
		logic [PixW-1:0] avg_g;
		logic [PixW-1:0] avg_b;
		logic [15:0]     detail;
		logic            split;
		logic            count_err;
	} region_result_t;

	// region predictor and store of expected result words
	class region_scoreboard;
		logic [23:0]     pixels [StoreDepth];
		int unsigned     sum_r, sum_g, sum_b;
		int unsigned     count;
		logic [CrdW-1:0] org_x, org_y;
		logic [DimW-1:0] dim_w, dim_h;
		logic [7:0]      threshold;
		region_result_t  pending_results [$];
		int              fails, regions, splits, errors;

		function void clear_region();
			sum_r = 0; sum_g = 0; sum_b = 0; count = 0;
			org_x = '0; org_y = '0; dim_w = '0; dim_h = '0;
		endfunction

		// one accepted pixel word
		function void note_pixel(logic [87:0] data, logic last);
			logic [7:0] r, g, b;
			longint unsigned area, s, denom;
			region_result_t res;
			int unsigned pr, pg, pb;
			r = data[7:0]; g = data[15:8]; b = data[23:16];
			if (count == 0) begin
				org_x = data[39:24];
				org_y = data[55:40];
				dim_w = data[68:56];
				dim_h = data[81:69];
			end
			if (count < StoreDepth) begin
				pixels[count] = {r, g, b};
				sum_r += r; sum_g += g; sum_b += b;
				count++;
			end else begin
				count = StoreDepth + 1;
			end
			if (!last)
				return;
			area = longint'(dim_w) * longint'(dim_h);
			res = '{org_x, org_y, 0, 0, 0, 0, 0, 0};
			res.count_err = (count > StoreDepth) || (area != count);
			if (!res.count_err) begin
				res.avg_r = 8'(sum_r / area);
				res.avg_g = 8'(sum_g / area);
				res.avg_b = 8'(sum_b / area);
				s = 0;
				for (int i = 0; i < count; i++) begin
					pr = 32'(pixels[i][23:16]);
					pg = 32'(pixels[i][15:8]);
					pb = 32'(pixels[i][7:0]);
					s += (pr > res.avg_r) ? pr - res.avg_r : res.avg_r - pr;
					s += (pg > res.avg_g) ? pg - res.avg_g : res.avg_g - pg;
					s += (pb > res.avg_b) ? pb - res.avg_b : res.avg_b - pb;
				end
				denom = 3 * area;
				res.detail = 16'((s * 256) / denom);
				res.split = s > longint'(threshold) * denom;
			end
			pending_results.push_back(res);
			clear_region();
		endfunction

		function void compare(string name, longint unsigned e, longint unsigned a);
			if (e != a) begin
				$error("%s mismatch: expected %0d, got %0d", name, e, a);
				fails++;
			end
		endfunction

		// one accepted result word
		function void check_result(logic [87:0] data);
			region_result_t e;
			if (pending_results.size() == 0) begin
				$error("result word with no region pending: %h", data);
				fails++;
				return;
			end
			e = pending_results.pop_front();
			compare("out_x", e.x, data[15:0]);
			compare("out_y", e.y, data[31:16]);
			compare("avg_red", e.avg_r, data[39:32]);
			compare("avg_green", e.avg_g, data[47:40]);
			compare("avg_blue", e.avg_b, data[55:48]);
			compare("detail_q8", e.detail, data[71:56]);
			compare("split", e.split, data[72]);
			compare("count_error", e.count_err, data[73]);
			regions++;
			splits += e.split;
			errors += e.count_err;
		endfunction
	endclass

	logic        clk, arst_n;
	logic        s_axis_tvalid, s_axis_tready, s_axis_tlast;
	// red, green, blue, region_x, region_y, region_width, region_height, pad
	logic [87:0] s_axis_tdata;
	logic        m_axis_tvalid, m_axis_tready;
	// out_x, out_y, avg_red, avg_green, avg_blue, detail_q8, split, count_error
	logic [87:0] m_axis_tdata;
	logic        cfg_valid, cfg_ready;
	logic [7:0]  cfg_data;

	region_scoreboard board = new();

	// idle percentages of the sender and the receiver, and a long hold request
	int send_idle_pct, recv_idle_pct;
	int recv_hold_req;
	int pixel_words;

	quadtree_region_split_test DUT (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// hard stop for a hung run
	initial begin
		#20ms;
		$display("tb failed");
		$finish;
	end

	// receiver: checks each accepted result word, then picks the next ready
	initial begin
		int hold_left;
		hold_left = 0;
		m_axis_tready = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready)
				board.check_result(m_axis_tdata);
			if (recv_hold_req > 0) begin
				hold_left = recv_hold_req;
				recv_hold_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	// one pixel word, with random idle cycles ahead of it
	task automatic send_pixel(logic [7:0] r, g, b, logic [15:0] x, y,
			logic [12:0] w, h, logic last);
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < send_idle_pct)
				@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {6'b0, h, w, y, x, b, g, r};
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		board.note_pixel({6'b0, h, w, y, x, b, g, r}, last);
		pixel_words++;
	endtask

	// one region of n pixels; later pixels carry random region fields
	// style 0 random, 1 flat color with small noise, 2 blue/yellow checker
	task automatic send_region(logic [15:0] x, y, logic [12:0] w, h, int n, int style);
		logic [7:0] r, g, b, br, bg, bb;
		br = 8'($urandom); bg = 8'($urandom); bb = 8'($urandom);
		for (int i = 0; i < n; i++) begin
			case (style)
				0: begin
					r = 8'($urandom); g = 8'($urandom); b = 8'($urandom);
				end
				1: begin
					r = br ^ 8'($urandom & 32'h07);
					g = bg ^ 8'($urandom & 32'h0f);
					b = bb ^ 8'($urandom & 32'h03);
				end
				default: begin
					r = i[0] ? 8'hff : 8'h00;
					g = r; b = ~r;
				end
			endcase
			if (i == 0)
				send_pixel(r, g, b, x, y, w, h, i == n - 1);
			else
				send_pixel(r, g, b, 16'($urandom), 16'($urandom), 13'($urandom),
					13'($urandom), i == n - 1);
		end
	endtask

	// back end must be idle: nothing pending, then its worst latency
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (board.pending_results.size() > 0)
			@(posedge clk);
		repeat (4200 + 300) @(posedge clk);
	endtask

	task automatic write_threshold(logic [7:0] value);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		board.threshold = value;
	endtask

	task automatic random_regions(int words);
		int target, w, h, n, kind;
		target = pixel_words + words;
		while (pixel_words < target) begin
			kind = $urandom_range(99);
			w = $urandom_range(1, 6);
			h = $urandom_range(1, 6);
			if (kind < 5) begin
				w = $urandom_range(1, 40);
				h = $urandom_range(1, 8);
			end
			n = w * h;
			if (kind >= 85 && kind < 92)
				n = $urandom_range(1, 20);
			else if (kind >= 92 && kind < 96) begin
				w = int'($urandom & 32'h1fff);
				h = int'($urandom & 32'h1fff);
				n = $urandom_range(1, 10);
			end else if (kind >= 96) begin
				w = kind[0] ? 0 : $urandom_range(1, 5);
				h = kind[0] ? $urandom_range(1, 5) : 0;
				n = $urandom_range(1, 5);
			end
			send_region(16'($urandom), 16'($urandom), 13'(w), 13'(h), n,
				int'($urandom_range(2)));
		end
	endtask

	initial begin
		logic [7:0] thresholds [5];
		thresholds = '{8'd0, 8'd255, 8'd3, 8'd20, 8'd60};
		arst_n = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tlast = 0;
		cfg_valid = 0;
		cfg_data = '0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		recv_hold_req = 0;
		pixel_words = 0;
		board.threshold = 0;
		board.clear_region();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: single pixels at both extremes under the reset threshold
		send_pixel(8'h00, 8'h00, 8'h00, 16'h0000, 16'h0000, 13'd1, 13'd1, 1'b1);
		send_pixel(8'hff, 8'hff, 8'hff, 16'hffff, 16'hffff, 13'd1, 13'd1, 1'b1);
		// checker 2x2: largest deviation
		send_region(16'h1234, 16'h4321, 13'd2, 13'd2, 4, 2);
		// zero width and zero height
		send_region(16'd7, 16'd9, 13'd0, 13'd3, 2, 0);
		send_region(16'd7, 16'd9, 13'd3, 13'd0, 1, 0);
		// short count and long count
		send_region(16'd1, 16'd2, 13'd1, 13'd3, 2, 0);
		send_region(16'd3, 16'd4, 13'd2, 13'd1, 3, 0);
		// flat 3x2 and random 2x3, with random size fields on later pixels
		send_region(16'd5, 16'd6, 13'd3, 13'd2, 6, 1);
		send_region(16'hff00, 16'h00ff, 13'd2, 13'd3, 6, 0);
		drain();

		// larger region under the top threshold
		write_threshold(8'd255);
		send_region(16'd64, 16'd64, 13'd20, 13'd16, 320, 0);
		drain();

		// random phases: idling pattern and threshold change per phase
		for (int ph = 0; ph < 10; ph++) begin
			write_threshold(ph < 5 ? thresholds[ph] : 8'($urandom_range(0, 40)));
			case (ph % 4)
				0: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
				1: begin send_idle_pct = 46; recv_idle_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_idle_pct = 46; end
				default: begin send_idle_pct = 25; recv_idle_pct = 25; end
			endcase
			// long receiver hold while pixels keep coming, so input stalls
			if (ph == 2)
				recv_hold_req = 600;
			random_regions(75);
			// sender pauses until every expected word has come
			drain();
		end

		send_idle_pct = 0;
		recv_idle_pct = 0;
		$display("covered %0d regions (%0d split, %0d count errors), %0d pixel words",
			board.regions, board.splits, board.errors, pixel_words);
		if (board.fails == 0 && board.pending_results.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

endmodule

// ----- sim.f -----
rtl/core/qrst_pkg.sv
rtl/core/qrst_ram.sv
rtl/core/qrst_divu.sv
rtl/core/qrst_front.sv
rtl/core/qrst_back.sv
rtl/core/quadtree_region_split_test.sv
tb/tb.sv
